### src/ntcadc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntcadc_pkg
// Shared widths, the thermistor code table and the stage payload types.
// ----------------------------------------------------------------------------
package ntcadc_pkg;

    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned TEMP_W     = 18;
    localparam int unsigned CODES_HELD = 166;
    localparam int unsigned IDX_W      = 8;   // holds 0..CODES_HELD
    localparam int unsigned GRP_W      = 16;  // compare bits per count group
    localparam int unsigned NGRP       = (CODES_HELD + GRP_W - 1) / GRP_W;
    localparam int unsigned GRP_CNT_W  = 5;   // holds 0..GRP_W
    localparam int unsigned QUO_W      = 10;  // correction < 1000 < 2**QUO_W
    localparam int unsigned PROD_W     = SAMPLE_W + QUO_W;
    localparam int          MILLI      = 1000;
    localparam int          LOWEST_DEG = -40;

    // ADC code per whole degree, -40 C upward; codes fall with temperature.
    localparam logic [SAMPLE_W-1:0] NTC_CODES [0:CODES_HELD-1] = '{
        12'd2726, 12'd2723, 12'd2720, 12'd2716, 12'd2712, 12'd2708, 12'd2703, 12'd2699,
        12'd2694, 12'd2688, 12'd2683, 12'd2677, 12'd2670, 12'd2664, 12'd2657, 12'd2649,
        12'd2641, 12'd2633, 12'd2624, 12'd2614, 12'd2605, 12'd2594, 12'd2583, 12'd2572,
        12'd2560, 12'd2547, 12'd2534, 12'd2520, 12'd2506, 12'd2491, 12'd2475, 12'd2459,
        12'd2442, 12'd2424, 12'd2405, 12'd2386, 12'd2366, 12'd2345, 12'd2324, 12'd2302,
        12'd2279, 12'd2256, 12'd2231, 12'd2206, 12'd2181, 12'd2154, 12'd2127, 12'd2099,
        12'd2071, 12'd2042, 12'd2012, 12'd1982, 12'd1952, 12'd1921, 12'd1889, 12'd1857,
        12'd1824, 12'd1792, 12'd1758, 12'd1725, 12'd1691, 12'd1658, 12'd1623, 12'd1589,
        12'd1555, 12'd1521, 12'd1487, 12'd1453, 12'd1419, 12'd1385, 12'd1351, 12'd1318,
        12'd1284, 12'd1252, 12'd1219, 12'd1187, 12'd1155, 12'd1123, 12'd1092, 12'd1062,
        12'd1032, 12'd1002, 12'd973,  12'd945,  12'd917,  12'd889,  12'd863,  12'd836,
        12'd811,  12'd786,  12'd761,  12'd737,  12'd714,  12'd692,  12'd670,  12'd648,
        12'd627,  12'd607,  12'd587,  12'd568,  12'd549,  12'd531,  12'd514,  12'd497,
        12'd480,  12'd464,  12'd449,  12'd434,  12'd420,  12'd406,  12'd392,  12'd379,
        12'd366,  12'd354,  12'd342,  12'd330,  12'd319,  12'd309,  12'd298,  12'd288,
        12'd279,  12'd269,  12'd260,  12'd252,  12'd243,  12'd235,  12'd227,  12'd220,
        12'd213,  12'd206,  12'd199,  12'd192,  12'd186,  12'd180,  12'd174,  12'd168,
        12'd163,  12'd158,  12'd152,  12'd147,  12'd143,  12'd138,  12'd134,  12'd129,
        12'd125,  12'd121,  12'd117,  12'd114,  12'd110,  12'd107,  12'd103,  12'd100,
        12'd97,   12'd94,   12'd91,   12'd88,   12'd86,   12'd83,   12'd80,   12'd78,
        12'd76,   12'd73,   12'd71,   12'd69,   12'd67,   12'd65
    };

    // Table read; an index past the end reads as zero.
    function automatic logic [SAMPLE_W-1:0] code_at(input logic [IDX_W-1:0] idx);
        logic [SAMPLE_W-1:0] code;
        code = '0;
        if (32'(idx) < CODES_HELD) begin
            code = NTC_CODES[idx];
        end
        return code;
    endfunction

    // Data that rides alongside the divider.
    typedef struct packed {
        logic [TEMP_W-1:0] base;   // entry temperature in millidegrees
        logic              kill;   // end point or flat step: no correction
    } side_t;

    // Divider input beat.
    typedef struct packed {
        logic [PROD_W-1:0]   prod;  // (sample - code_low) * 1000
        logic [SAMPLE_W-1:0] den;   // code_high - code_low
        side_t               side;
    } interp_t;

    // One divider stage.
    typedef struct packed {
        logic [SAMPLE_W-1:0] rem;
        logic [QUO_W-1:0]    low;
        logic [QUO_W-1:0]    quo;
        logic [SAMPLE_W-1:0] den;
        side_t               side;
    } div_t;

endpackage
`default_nettype wire

### src/ntcadc_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntcadc_search
// Three-stage table search: compare, group counts, index sum.
// ----------------------------------------------------------------------------
module ntcadc_search #(
    parameter int unsigned POINTS = 166
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              adv,
    input  wire logic                              in_valid,
    input  wire logic [ntcadc_pkg::SAMPLE_W-1:0]   in_sample,
    output logic                                   out_valid,
    output logic [ntcadc_pkg::SAMPLE_W-1:0]        out_sample,
    output logic [ntcadc_pkg::IDX_W-1:0]           out_idx
);

    localparam int unsigned LT_W = ntcadc_pkg::NGRP * ntcadc_pkg::GRP_W;

    logic [LT_W-1:0]                     lt_next, lt_reg;
    logic [ntcadc_pkg::GRP_CNT_W-1:0]    cnt_next [0:ntcadc_pkg::NGRP-1];
    logic [ntcadc_pkg::GRP_CNT_W-1:0]    cnt_reg  [0:ntcadc_pkg::NGRP-1];
    logic [ntcadc_pkg::IDX_W-1:0]        idx_next, idx_reg;
    logic [ntcadc_pkg::SAMPLE_W-1:0]     s1_sample_reg, s2_sample_reg, s3_sample_reg;
    logic                                s1_valid_reg, s2_valid_reg, s3_valid_reg;

    // Codes fall monotonically, so the compare vector is a thermometer and
    // its population count is the first index with code <= sample.
    always_comb begin
        lt_next = '0;
        for (int k = 0; k < ntcadc_pkg::CODES_HELD; k++) begin
            if (k < POINTS) begin
                lt_next[k] = (in_sample < ntcadc_pkg::NTC_CODES[k]);
            end
        end
    end

    always_comb begin
        for (int g = 0; g < ntcadc_pkg::NGRP; g++) begin
            cnt_next[g] = ntcadc_pkg::GRP_CNT_W'(
                $countones(lt_reg[g*ntcadc_pkg::GRP_W +: ntcadc_pkg::GRP_W]));
        end
    end

    always_comb begin
        idx_next = '0;
        for (int g = 0; g < ntcadc_pkg::NGRP; g++) begin
            idx_next = idx_next + ntcadc_pkg::IDX_W'(cnt_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lt_reg        <= lt_next;
            s1_sample_reg <= in_sample;
            cnt_reg       <= cnt_next;
            s2_sample_reg <= s1_sample_reg;
            idx_reg       <= idx_next;
            s3_sample_reg <= s2_sample_reg;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_sample = s3_sample_reg;
    assign out_idx    = idx_reg;

endmodule
`default_nettype wire

### src/ntcadc_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntcadc_prep
// Two stages: neighbour lookup and operands, then scaling by 1000.
// ----------------------------------------------------------------------------
module ntcadc_prep #(
    parameter int unsigned POINTS = 166
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              adv,
    input  wire logic                              in_valid,
    input  wire logic [ntcadc_pkg::SAMPLE_W-1:0]   in_sample,
    input  wire logic [ntcadc_pkg::IDX_W-1:0]      in_idx,
    output logic                                   out_valid,
    output ntcadc_pkg::interp_t                    out_data
);

    localparam logic [ntcadc_pkg::IDX_W-1:0] LAST_IDX = ntcadc_pkg::IDX_W'(POINTS - 1);

    logic [ntcadc_pkg::SAMPLE_W-1:0] hi, lo, num_next, num_reg, den_next, den_reg;
    logic [ntcadc_pkg::IDX_W-1:0]    eidx;
    logic                            is_first, is_last;
    ntcadc_pkg::side_t               side_next, side_reg;
    ntcadc_pkg::interp_t             data_next, data_reg;
    logic                            s4_valid_reg, s5_valid_reg;

    always_comb begin
        hi       = ntcadc_pkg::code_at(in_idx - ntcadc_pkg::IDX_W'(1));
        lo       = ntcadc_pkg::code_at(in_idx);
        is_first = (in_idx == '0);
        is_last  = (in_idx >= LAST_IDX);
        eidx     = is_last ? LAST_IDX : in_idx;
        num_next = in_sample - lo;
        den_next = hi - lo;
        side_next.kill = is_first || is_last || (hi <= lo);
        side_next.base = ntcadc_pkg::TEMP_W'(eidx) * ntcadc_pkg::TEMP_W'(ntcadc_pkg::MILLI)
                       + ntcadc_pkg::TEMP_W'(ntcadc_pkg::LOWEST_DEG * ntcadc_pkg::MILLI);
    end

    always_comb begin
        data_next.prod = ntcadc_pkg::PROD_W'(num_reg)
                       * ntcadc_pkg::PROD_W'(ntcadc_pkg::MILLI);
        data_next.den  = den_reg;
        data_next.side = side_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= in_valid;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
            data_reg <= data_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

### src/ntcadc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntcadc_divider
// Restoring divider, one quotient bit per stage. Needs prod < den * 2**QUO_W.
// ----------------------------------------------------------------------------
module ntcadc_divider (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           adv,
    input  wire logic                           in_valid,
    input  wire ntcadc_pkg::interp_t            in_data,
    output logic                                out_valid,
    output logic [ntcadc_pkg::QUO_W-1:0]        out_quo,
    output ntcadc_pkg::side_t                   out_side
);

    localparam int unsigned NST = ntcadc_pkg::QUO_W;

    ntcadc_pkg::div_t st_in;
    ntcadc_pkg::div_t st_next [0:NST-1];
    ntcadc_pkg::div_t st_reg  [0:NST-1];
    logic [NST-1:0]   valid_reg;

    function automatic ntcadc_pkg::div_t div_step(input ntcadc_pkg::div_t d);
        ntcadc_pkg::div_t              r;
        logic [ntcadc_pkg::SAMPLE_W:0] trial;
        logic                          take;
        r     = d;
        trial = {d.rem, d.low[ntcadc_pkg::QUO_W-1]};
        take  = (trial >= {1'b0, d.den});
        r.rem = take ? ntcadc_pkg::SAMPLE_W'(trial - {1'b0, d.den})
                     : trial[ntcadc_pkg::SAMPLE_W-1:0];
        r.low = {d.low[ntcadc_pkg::QUO_W-2:0], 1'b0};
        r.quo = {d.quo[ntcadc_pkg::QUO_W-2:0], take};
        return r;
    endfunction

    always_comb begin
        st_in.rem  = in_data.prod[ntcadc_pkg::PROD_W-1:ntcadc_pkg::QUO_W];
        st_in.low  = in_data.prod[ntcadc_pkg::QUO_W-1:0];
        st_in.quo  = '0;
        st_in.den  = in_data.den;
        st_in.side = in_data.side;
    end

    always_comb begin
        st_next[0] = div_step(st_in);
        for (int s = 1; s < NST; s++) begin
            st_next[s] = div_step(st_reg[s-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_quo   = st_reg[NST-1].quo;
    assign out_side  = st_reg[NST-1].side;

endmodule
`default_nettype wire

### src/ntc_adc_to_temperature.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// NTC thermistor ADC code to millidegrees Celsius by table interpolation.
// ----------------------------------------------------------------------------
//  channel  dir  ports                                   beat
//  s_       in   s_valid, s_ready, s_adc_sample[11:0]     one ADC sample
//  m_       out  m_valid, m_ready, m_temp_millicelsius    one temperature
//                [17:0] (signed)
//
//  One sample per cycle while the output is not stalled. Stages from input to
//  output: 3 search, 2 operand, 10 divider (one quotient bit each), 1 output.
//  Reset (aresetn, synchronous) clears the valid bits only.
//  All stages advance together when the output register is empty or taken;
//  s_ready follows that, so a stalled output holds the whole pipe intact.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature #(
    parameter int unsigned TABLE_POINTS = 166
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [ntcadc_pkg::SAMPLE_W-1:0]       s_adc_sample,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [ntcadc_pkg::TEMP_W-1:0]       m_temp_millicelsius
);

    // Entries in use, clamped to what the table holds and to at least two.
    localparam int unsigned POINTS =
        (TABLE_POINTS > ntcadc_pkg::CODES_HELD) ? ntcadc_pkg::CODES_HELD :
        (TABLE_POINTS < 2) ? 2 : TABLE_POINTS;

    logic                               adv;
    logic                               srch_valid;
    logic [ntcadc_pkg::SAMPLE_W-1:0]    srch_sample;
    logic [ntcadc_pkg::IDX_W-1:0]       srch_idx;
    logic                               prep_valid;
    ntcadc_pkg::interp_t                prep_data;
    logic                               div_valid;
    logic [ntcadc_pkg::QUO_W-1:0]       div_quo;
    ntcadc_pkg::side_t                  div_side;
    logic [ntcadc_pkg::TEMP_W-1:0]      temp_next, temp_reg;
    logic                               m_valid_reg;

    // Global advance: the output register is free or being taken this cycle.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Index i of the first entry with code <= sample (POINTS if none).
    ntcadc_search #(.POINTS(POINTS)) u_search (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_valid),
        .in_sample  (s_adc_sample),
        .out_valid  (srch_valid),
        .out_sample (srch_sample),
        .out_idx    (srch_idx)
    );

    // Neighbour codes, end-point flags, entry temperature, scaled numerator.
    ntcadc_prep #(.POINTS(POINTS)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (srch_valid),
        .in_sample (srch_sample),
        .in_idx    (srch_idx),
        .out_valid (prep_valid),
        .out_data  (prep_data)
    );

    // Truncated correction: (sample - lo) * 1000 / (hi - lo), < 1000 when applied.
    ntcadc_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (prep_valid),
        .in_data   (prep_data),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // End points and flat steps take the entry temperature as it is.
    always_comb begin
        temp_next = div_side.base;
        if (!div_side.kill) begin
            temp_next = div_side.base - ntcadc_pkg::TEMP_W'(div_quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            temp_reg <= temp_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_temp_millicelsius = $signed(temp_reg);

endmodule
`default_nettype wire

### src/ntcadc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntcadc_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module ntcadc_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_valid,
    input wire logic                                 s_ready,
    input wire logic [ntcadc_pkg::SAMPLE_W-1:0]      s_adc_sample,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic signed [ntcadc_pkg::TEMP_W-1:0] m_temp_millicelsius
);

    localparam logic signed [ntcadc_pkg::TEMP_W-1:0] T_MIN = -18'sd40000;
    localparam logic signed [ntcadc_pkg::TEMP_W-1:0] T_MAX = 18'sd125000;

    // Stalled output beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_temp_millicelsius)))
        else $error("output beat changed while stalled");

    // Results stay within the table's temperature span.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temp_millicelsius >= T_MIN && m_temp_millicelsius <= T_MAX))
        else $error("temperature out of range");

    // A stalled output stalls intake.
    a_stall_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("sample taken while output stalled");

    // No output beat straight after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // An empty output register never blocks intake.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("intake blocked with empty output");

endmodule

bind ntc_adc_to_temperature ntcadc_checker u_ntcadc_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .s_adc_sample        (s_adc_sample),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_temp_millicelsius (m_temp_millicelsius)
);
`default_nettype wire
